/* rtl/core/sts_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the sorted table search core.
// Used by sts_ctrl, sts_dpath and sorted_table_search_core; no dependencies.
package sts_pkg;

	localparam int DEF_CAPACITY = 256;

	// request codes
	localparam logic [2:0] REQ_INSERT = 3'd0;
	localparam logic [2:0] REQ_SEARCH = 3'd1;
	localparam logic [2:0] REQ_REMOVE = 3'd2;
	localparam logic [2:0] REQ_READ   = 3'd3;
	localparam logic [2:0] REQ_CLEAR  = 3'd4;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_INC  = 2'd1,
		CNT_DEC  = 2'd2,
		CNT_CLR  = 2'd3
	} cnt_op_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;       // capture request, init pointers
		logic       ins_rd;     // read entry below insert position
		logic       ins_shift;  // move read entry up, step position down
		logic       ins_place;  // write new value at insert position
		logic       srch_rd;    // read midpoint, capture it
		logic       srch_step;  // narrow search window
		logic       idx_rd;     // read entry at requested index
		logic       finish;     // issue result
		logic [2:0] status;
		cnt_op_t    cnt_op;
		logic       sel_found;
		logic       sel_read;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] req;
		logic       full;
		logic       empty;
		logic       pos_zero;
		logic       idx_ok;
		logic       srch_end;
		logic       gt;
		logic       eq;
	} sts_t;

endpackage

/* rtl/core/sts_ctrl.sv */
`timescale 1ns / 1ps
// Request sequencer for the sorted table search core.
// Depends on sts_pkg for command/status structs and codes.
module sts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sts_pkg::sts_t sts,
	output sts_pkg::cmd_t cmd
);
	import sts_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_DISPATCH = 5'b00010,
		S_INS_CMP  = 5'b00100,
		S_SRCH_CMP = 5'b01000,
		S_RD_WAIT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		cmd.status = ST_OK;
		cmd.cnt_op = CNT_HOLD;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.req)
					REQ_INSERT: begin
						if (sts.full) begin
							cmd.finish = 1'b1;
							cmd.status = ST_FULL;
							state_d    = S_IDLE;
						end else if (sts.pos_zero) begin
							cmd.ins_place = 1'b1;
							cmd.finish    = 1'b1;
							cmd.cnt_op    = CNT_INC;
							state_d       = S_IDLE;
						end else begin
							cmd.ins_rd = 1'b1;
							state_d    = S_INS_CMP;
						end
					end
					REQ_SEARCH: begin
						if (sts.srch_end) begin
							cmd.finish = 1'b1;
							cmd.status = ST_NOT_FOUND;
							state_d    = S_IDLE;
						end else begin
							cmd.srch_rd = 1'b1;
							state_d     = S_SRCH_CMP;
						end
					end
					REQ_REMOVE: begin
						cmd.finish = 1'b1;
						if (sts.empty) begin
							cmd.status = ST_EMPTY;
						end else begin
							cmd.cnt_op = CNT_DEC;
						end
						state_d = S_IDLE;
					end
					REQ_READ: begin
						if (sts.idx_ok) begin
							cmd.idx_rd = 1'b1;
							state_d    = S_RD_WAIT;
						end else begin
							cmd.finish = 1'b1;
							cmd.status = ST_RANGE;
							state_d    = S_IDLE;
						end
					end
					REQ_CLEAR: begin
						cmd.finish = 1'b1;
						cmd.cnt_op = CNT_CLR;
						state_d    = S_IDLE;
					end
					default: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_INS_CMP: begin
				if (sts.gt) begin
					// larger entry: move it up and keep walking down
					cmd.ins_shift = 1'b1;
					state_d       = S_DISPATCH;
				end else begin
					cmd.ins_place = 1'b1;
					cmd.finish    = 1'b1;
					cmd.cnt_op    = CNT_INC;
					state_d       = S_IDLE;
				end
			end
			S_SRCH_CMP: begin
				if (sts.eq) begin
					cmd.finish    = 1'b1;
					cmd.sel_found = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.srch_step = 1'b1;
					state_d       = S_DISPATCH;
				end
			end
			S_RD_WAIT: begin
				cmd.finish   = 1'b1;
				cmd.sel_read = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/sts_dpath.sv */
`timescale 1ns / 1ps
// Datapath of the sorted table search core: entry memory, count, pointers,
// comparators and result registers. Depends on sts_pkg.
module sts_dpath #(
	parameter int CAPACITY = sts_pkg::DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] value,
	input  logic [7:0]         index,
	input  sts_pkg::cmd_t      cmd,
	output sts_pkg::sts_t      sts,
	output logic               done,
	output logic [2:0]         status,
	output logic [7:0]         found_index,
	output logic signed [31:0] read_value,
	output logic [8:0]         count
);
	import sts_pkg::*;

	localparam int AW   = $clog2(CAPACITY);
	localparam int CNTW = $clog2(CAPACITY + 1);
	localparam int CMPW = (CNTW > 8) ? CNTW : 8;
	localparam int OCW  = (CNTW > 9) ? CNTW : 9;

	logic signed [31:0] mem [CAPACITY];

	logic [CNTW-1:0]    count_q;
	logic [CNTW-1:0]    pos_q;
	logic [CNTW-1:0]    lo_q;
	logic [CNTW-1:0]    hx_q;   // exclusive upper bound
	logic [AW-1:0]      mid_q;
	logic signed [31:0] value_q;
	logic [2:0]         req_q;
	logic [7:0]         index_q;
	logic signed [31:0] rdata_q;
	logic               done_q;
	logic [2:0]         status_q;
	logic [7:0]         found_q;
	logic signed [31:0] rdval_q;

	logic [CNTW-1:0]    pos_m1;
	logic [CNTW:0]      mid_sum;
	logic [AW-1:0]      mid_c;
	logic [CMPW-1:0]    idx_ext;
	logic [CMPW-1:0]    cnt_ext;
	logic [CMPW-1:0]    mid_ext;
	logic [OCW-1:0]     cnt_out;
	logic [AW-1:0]      mem_addr;
	logic               mem_we;
	logic               mem_re;
	logic signed [31:0] mem_wdata;

	assign pos_m1  = pos_q - CNTW'(1);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hx_q} - (CNTW + 1)'(1);
	assign mid_c   = mid_sum[AW:1];
	assign idx_ext = CMPW'(index_q);
	assign cnt_ext = CMPW'(count_q);
	assign mid_ext = CMPW'(mid_q);
	assign cnt_out = OCW'(count_q);

	always_comb begin
		sts.req      = req_q;
		sts.full     = (count_q == CNTW'(CAPACITY));
		sts.empty    = (count_q == '0);
		sts.pos_zero = (pos_q == '0);
		sts.idx_ok   = (idx_ext < cnt_ext);
		sts.srch_end = (lo_q >= hx_q);
		sts.gt       = (rdata_q > value_q);
		sts.eq       = (rdata_q == value_q);
	end

	always_comb begin
		mem_addr = pos_q[AW-1:0];
		if (cmd.ins_rd) begin
			mem_addr = pos_m1[AW-1:0];
		end else if (cmd.srch_rd) begin
			mem_addr = mid_c;
		end else if (cmd.idx_rd) begin
			mem_addr = idx_ext[AW-1:0];
		end
		mem_we    = cmd.ins_shift | cmd.ins_place;
		mem_re    = cmd.ins_rd | cmd.srch_rd | cmd.idx_rd;
		mem_wdata = cmd.ins_shift ? rdata_q : value_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			case (cmd.cnt_op)
				CNT_INC: count_q <= count_q + CNTW'(1);
				CNT_DEC: count_q <= count_q - CNTW'(1);
				CNT_CLR: count_q <= '0;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			value_q <= value;
			index_q <= index;
			pos_q   <= count_q;
			lo_q    <= '0;
			hx_q    <= count_q;
		end
		if (cmd.ins_shift) begin
			pos_q <= pos_m1;
		end
		if (cmd.srch_rd) begin
			mid_q <= mid_c;
		end
		if (cmd.srch_step) begin
			if (rdata_q < value_q) begin
				lo_q <= CNTW'(mid_q) + CNTW'(1);
			end else begin
				hx_q <= CNTW'(mid_q);
			end
		end
		if (cmd.finish) begin
			status_q <= cmd.status;
			found_q  <= cmd.sel_found ? mid_ext[7:0] : 8'd0;
			rdval_q  <= cmd.sel_read ? rdata_q : 32'sd0;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign read_value  = rdval_q;
	assign count       = cnt_out[8:0];

endmodule

/* rtl/core/sorted_table_search_core.sv */
`timescale 1ns / 1ps
// Top level of the sorted table search core: sequencer plus datapath.
// Depends on sts_pkg, sts_ctrl and sts_dpath.
//
// Usage: drive req_type, value and index and raise start while busy is low;
// that edge transfers the request. busy stays high until the result is
// issued. Each request yields one result: done is high for exactly one
// cycle with status, found_index, read_value and count; the receiver must
// take it then, it cannot stall the block. A new request may be started in
// the cycle done is shown.
// Insert walks down from the top of the table, moving each larger entry up
// one position, and is refused when the table is full; search probes by
// binary search until a match or an empty window; read is refused out of
// range; remove, clear and unused codes finish without a memory access.
// Each move or probe is a registered read from the single-port entry
// memory followed by a compare (and write) step.
// After reset the table is empty (count 0); entry contents are undefined
// until written, but no position at or above the count is ever read.
module sorted_table_search_core #(
	parameter int CAPACITY = sts_pkg::DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] value,
	input  logic [7:0]         index,
	output logic               done,
	output logic [2:0]         status,
	output logic [7:0]         found_index,
	output logic signed [31:0] read_value,
	output logic [8:0]         count
);
	import sts_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	sts_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_type    (req_type),
		.value       (value),
		.index       (index),
		.cmd         (cmd),
		.sts         (sts),
		.done        (done),
		.status      (status),
		.found_index (found_index),
		.read_value  (read_value),
		.count       (count)
	);

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for sorted_table_search_core: directed requests, then random
// fill, drain and mixed phases; checked against a behavioral copy or typed results.
// Depends on sts_pkg and the core RTL.
module tb_top;
	import sts_pkg::*;

	localparam int CAPACITY = DEF_CAPACITY;
	localparam int CLK_PERIOD = 10;
	localparam int IDLE_PCT = 15;
	localparam int RANDOM_ITEMS = 1145;
	localparam int TAIL_CYCLES = 2 * CAPACITY + 8;
	localparam int LIMIT_CYCLES = 3_500_000;
	localparam int PRINT_LIMIT = 40;

	localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REQ_SPARE_LAST = 3'd7;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

	typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [7:0]         found_index;
		logic signed [31:0] read_value;
		logic [8:0]         count;
	} response_t;

	typedef struct {
		logic [2:0]         req;
		logic signed [31:0] val;
		logic [7:0]         idx;
		bit                 typed;
		response_t          resp;
	} stim_row_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         req_type = '0;
	logic signed [31:0] value = '0;
	logic [7:0]         index = '0;
	logic               done;
	logic [2:0]         status;
	logic [7:0]         found_index;
	logic signed [31:0] read_value;
	logic [8:0]         count;

	// behavioral copy of the table
	logic signed [31:0] sorted_copy [CAPACITY];
	int                 copy_count;

	response_t          expected_responses [$];
	stim_row_t          directed_rows [$];
	int                 err_count;
	bit                 idle_enabled;

	sorted_table_search_core #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.value(value),
		.index(index),
		.done(done),
		.status(status),
		.found_index(found_index),
		.read_value(read_value),
		.count(count)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Apply one request to the table copy and return the response it gives.
	function automatic response_t predict_response(input logic [2:0] rq,
			input logic signed [31:0] v, input logic [7:0] ix);
		response_t r;
		int pos;
		int lo;
		int hi;
		int mid;
		r = '0;
		case (rq)
			REQ_INSERT: begin
				if (copy_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					// equal entries stay below the new one
					pos = copy_count;
					while (pos > 0 && sorted_copy[pos - 1] > v) begin
						sorted_copy[pos] = sorted_copy[pos - 1];
						pos--;
					end
					sorted_copy[pos] = v;
					copy_count++;
				end
			end
			REQ_SEARCH: begin
				r.status = ST_NOT_FOUND;
				lo = 0;
				hi = copy_count - 1;
				while (lo <= hi) begin
					mid = lo + (hi - lo) / 2;
					if (sorted_copy[mid] == v) begin
						r.status = ST_OK;
						r.found_index = mid[7:0];
						break;
					end
					if (sorted_copy[mid] < v)
						lo = mid + 1;
					else
						hi = mid - 1;
				end
			end
			REQ_REMOVE: begin
				if (copy_count == 0)
					r.status = ST_EMPTY;
				else
					copy_count--;
			end
			REQ_READ: begin
				if (int'(ix) < copy_count)
					r.read_value = sorted_copy[ix];
				else
					r.status = ST_RANGE;
			end
			REQ_CLEAR: begin
				copy_count = 0;
			end
			default: ;
		endcase
		r.count = copy_count[8:0];
		return r;
	endfunction

	// Offer one request until transferred; start may drop at random while waiting.
	task automatic send_request(input logic [2:0] rq, input logic signed [31:0] v,
			input logic [7:0] ix, input bit typed, input response_t typed_resp);
		response_t predicted;
		bit accepted;
		req_type <= rq;
		value <= v;
		index <= ix;
		accepted = 1'b0;
		while (!accepted) begin
			start <= !(idle_enabled && $urandom_range(99) < IDLE_PCT);
			@(posedge clk);
			accepted = start && !busy;
		end
		predicted = predict_response(rq, v, ix);
		expected_responses.push_back(typed ? typed_resp : predicted);
	endtask

	// Hold off until every pending result has come back.
	task automatic wait_results;
		start <= 1'b0;
		do @(posedge clk); while (expected_responses.size() > 0);
	endtask

	function automatic logic signed [31:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 30)
			return $signed($urandom_range(6)) - 3;
		if (roll < 40) begin
			case ($urandom_range(4))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return -1;
				3: return 1;
				default: return 0;
			endcase
		end
		if (roll < 60 && copy_count > 0)
			return sorted_copy[$urandom_range(copy_count - 1)];
		return $signed($urandom);
	endfunction

	function automatic logic [2:0] choose_req(input mix_t mix);
		int roll;
		roll = $urandom_range(99);
		case (mix)
			MIX_FILL: begin
				if (roll < 85) return REQ_INSERT;
				if (roll < 93) return REQ_SEARCH;
				return REQ_READ;
			end
			MIX_DRAIN: begin
				if (roll < 80) return REQ_REMOVE;
				if (roll < 90) return REQ_SEARCH;
				return REQ_READ;
			end
			default: begin
				if (roll < 40) return REQ_INSERT;
				if (roll < 65) return REQ_SEARCH;
				if (roll < 77) return REQ_REMOVE;
				if (roll < 94) return REQ_READ;
				if (roll < 97) return REQ_CLEAR;
				return 3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
			end
		endcase
	endfunction

	task automatic send_random(input logic [2:0] rq);
		logic signed [31:0] v;
		logic [7:0] ix;
		v = $signed($urandom);
		ix = 8'($urandom_range(255));
		if (rq == REQ_INSERT)
			v = pick_value();
		if (rq == REQ_SEARCH) begin
			if (copy_count > 0 && $urandom_range(99) < 60)
				v = sorted_copy[$urandom_range(copy_count - 1)];
			else
				v = pick_value();
		end
		if (rq == REQ_READ && copy_count > 0 && $urandom_range(99) < 70)
			ix = 8'($urandom_range(copy_count - 1));
		send_request(rq, v, ix, 1'b0, '0);
	endtask

	function automatic stim_row_t mk_row(input logic [2:0] rq, input logic signed [31:0] v,
			input logic [7:0] ix, input bit typed = 1'b0, input logic [2:0] st = ST_OK,
			input logic signed [31:0] rd = 0, input logic [8:0] cnt = 0);
		stim_row_t r;
		r.req = rq;
		r.val = v;
		r.idx = ix;
		r.typed = typed;
		r.resp = '{status: st, found_index: 8'd0, read_value: rd, count: cnt};
		return r;
	endfunction

	// result checker: every done must match the oldest pending response
	always @(posedge clk) begin : check_results
		response_t want;
		if (arst_n && done) begin
			if (expected_responses.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, status %0d", status));
			end else begin
				want = expected_responses.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", status, want.status));
				if (found_index !== want.found_index)
					report_mismatch($sformatf("found_index %0d, want %0d",
						found_index, want.found_index));
				if (read_value !== want.read_value)
					report_mismatch($sformatf("read_value %0d, want %0d",
						read_value, want.read_value));
				if (count !== want.count)
					report_mismatch($sformatf("count %0d, want %0d", count, want.count));
			end
		end
	end

	initial begin : run_limit
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		int sent;
		stim_row_t row;
		err_count = 0;
		copy_count = 0;
		idle_enabled = 1'b1;

		// empty-table cases
		directed_rows.push_back(mk_row(REQ_READ, 0, 8'd0, 1'b1, ST_RANGE, 0, 9'd0));
		directed_rows.push_back(mk_row(REQ_READ, 0, 8'd255, 1'b1, ST_RANGE, 0, 9'd0));
		directed_rows.push_back(mk_row(REQ_REMOVE, 0, 8'd0, 1'b1, ST_EMPTY, 0, 9'd0));
		directed_rows.push_back(mk_row(REQ_SEARCH, 0, 8'd0, 1'b1, ST_NOT_FOUND, 0, 9'd0));
		// extremes, duplicates and a negative
		directed_rows.push_back(mk_row(REQ_INSERT, VAL_MAX, 8'd0, 1'b1, ST_OK, 0, 9'd1));
		directed_rows.push_back(mk_row(REQ_INSERT, VAL_MIN, 8'd255, 1'b1, ST_OK, 0, 9'd2));
		directed_rows.push_back(mk_row(REQ_INSERT, 0, 8'd0));
		directed_rows.push_back(mk_row(REQ_INSERT, 0, 8'd0));
		directed_rows.push_back(mk_row(REQ_INSERT, -1, 8'd0));
		directed_rows.push_back(mk_row(REQ_INSERT, 1, 8'd0));
		directed_rows.push_back(mk_row(REQ_READ, 0, 8'd0, 1'b1, ST_OK, VAL_MIN, 9'd6));
		directed_rows.push_back(mk_row(REQ_READ, 0, 8'd5, 1'b1, ST_OK, VAL_MAX, 9'd6));
		directed_rows.push_back(mk_row(REQ_READ, 0, 8'd6, 1'b1, ST_RANGE, 0, 9'd6));
		directed_rows.push_back(mk_row(REQ_SEARCH, VAL_MAX, 8'd0));
		directed_rows.push_back(mk_row(REQ_SEARCH, VAL_MIN, 8'd0));
		directed_rows.push_back(mk_row(REQ_SEARCH, 0, 8'd0));
		directed_rows.push_back(mk_row(REQ_SEARCH, 2, 8'd0));
		// spare codes change nothing
		directed_rows.push_back(mk_row(REQ_SPARE_FIRST, -1, 8'd255, 1'b1, ST_OK, 0, 9'd6));
		directed_rows.push_back(mk_row(REQ_SPARE_FIRST + 3'd1, VAL_MIN, 8'd3,
			1'b1, ST_OK, 0, 9'd6));
		directed_rows.push_back(mk_row(REQ_SPARE_LAST, VAL_MAX, 8'd0, 1'b1, ST_OK, 0, 9'd6));
		directed_rows.push_back(mk_row(REQ_REMOVE, 0, 8'd0));
		directed_rows.push_back(mk_row(REQ_SEARCH, VAL_MAX, 8'd0));
		directed_rows.push_back(mk_row(REQ_CLEAR, 0, 8'd0, 1'b1, ST_OK, 0, 9'd0));
		directed_rows.push_back(mk_row(REQ_SEARCH, -1, 8'd0, 1'b1, ST_NOT_FOUND, 0, 9'd0));
		directed_rows.push_back(mk_row(REQ_INSERT, -1, 8'd0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_request(row.req, row.val, row.idx, row.typed, row.resp);
		end
		wait_results();

		sent = 0;
		// balanced warm-up
		repeat (150) begin
			send_random(choose_req(MIX_BALANCED));
			sent++;
		end
		wait_results();

		// fill to capacity back to back, then push against the full table
		idle_enabled = 1'b0;
		while (copy_count < CAPACITY) begin
			send_random(choose_req(MIX_FILL));
			sent++;
		end
		idle_enabled = 1'b1;
		repeat (6) begin
			send_random(REQ_INSERT);
			sent++;
		end
		repeat (20) begin
			send_random($urandom_range(1) ? REQ_SEARCH : REQ_READ);
			sent++;
		end
		wait_results();

		// drain down to empty and past it
		while (copy_count > 0) begin
			send_random(choose_req(MIX_DRAIN));
			sent++;
		end
		repeat (3) begin
			send_random(REQ_REMOVE);
			sent++;
		end
		send_random(REQ_READ);
		send_random(REQ_SEARCH);
		sent += 2;

		while (sent < RANDOM_ITEMS) begin
			send_random(choose_req(MIX_BALANCED));
			sent++;
		end
		start <= 1'b0;

		while (expected_responses.size() > 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
